// File: hw/rtl/nmea_rmc_gga_field_extractor_defines.svh
// Assertion macros used by the checker file of the NMEA field extractor.
// No dependencies; include by bare file name.
`ifndef NMEA_RMC_GGA_FIELD_EXTRACTOR_DEFINES_SVH
`define NMEA_RMC_GGA_FIELD_EXTRACTOR_DEFINES_SVH

// Plain property, checked at every clock edge outside reset.
`define NMEAX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define NMEAX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/nmeax_pkg.sv
// Types, codes and constants of the NMEA RMC/GGA field extractor.
// No dependencies.
package nmeax_pkg;

  localparam int unsigned TIME_DIVISOR_DEF = 100;

  localparam logic [27:0] RMC_POS_RESET = 28'h5746A98;
  localparam logic [15:0] GGA_POS_RESET = 16'hA982;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_RMC_POS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GGA_POS = 1'b1;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_TUSER_W = 5;

  typedef enum logic [1:0] {
    FUNC_FEED      = 2'd0,
    FUNC_BEGIN_RMC = 2'd1,
    FUNC_BEGIN_GGA = 2'd2,
    FUNC_NOP       = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    FC_SPEED   = 4'd0,
    FC_DATE    = 4'd1,
    FC_TRACK   = 4'd2,
    FC_LONG    = 4'd3,
    FC_LAT     = 4'd4,
    FC_TIME    = 4'd5,
    FC_SATS    = 4'd6,
    FC_HDOP    = 4'd7,
    FC_ALT     = 4'd8,
    FC_LONGDIR = 4'd9,
    FC_LATDIR  = 4'd10
  } field_code_e;

  localparam int unsigned FLAG_SPEED   = 0;
  localparam int unsigned FLAG_ALTI    = 1;
  localparam int unsigned FLAG_DATE    = 2;
  localparam int unsigned FLAG_BEARING = 3;
  localparam int unsigned FLAG_LONG    = 4;
  localparam int unsigned FLAG_LAT     = 5;

  typedef struct packed {
    logic        captured;
    field_code_e code;
    logic [31:0] value;
    logic [3:0]  frac;
    logic [5:0]  flags;
    logic        is_time;
  } res_t;

endpackage

// File: hw/rtl/nmeax_parser.sv
// Sentence state, configuration registers and field capture for one accepted item per cycle.
// Depends on nmeax_pkg.
module nmeax_parser import nmeax_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  logic [1:0]            func_i,
  input  logic [7:0]            data_byte_i,
  input  logic [5:0]            clear_mask_i,
  output res_t                  res_o
);

  logic [27:0] rmc_q;
  logic [15:0] gga_q;
  logic [1:0]  mode_q, mode_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  dcnt_q, dcnt_d;
  logic        seen_q, seen_d;
  logic [7:0]  letter_q, letter_d;
  logic [5:0]  flags_q, flags_d;

  logic [7:0]  digit_off;
  logic [4:0]  cnt_inc;
  logic [1:0]  mode_feed;
  logic        is_digit;
  res_t        res;

  function automatic logic pos_hit(input logic [4:0] n, input logic [3:0] pos);
    pos_hit = (n == {1'b0, pos});
  endfunction

  assign digit_off = data_byte_i - CH_ZERO;
  assign cnt_inc   = cnt_q + 5'd1;
  assign is_digit  = data_byte_i inside {[CH_ZERO:CH_NINE]};
  assign mode_feed = (data_byte_i == CH_STAR) ? 2'b00 : mode_q;

  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    dcnt_d   = dcnt_q;
    seen_d   = seen_q;
    letter_d = letter_q;
    flags_d  = flags_q;
    res      = '0;
    if (accept_i) begin
      flags_d = flags_q & ~clear_mask_i;
      case (func_e'(func_i))
        FUNC_BEGIN_RMC, FUNC_BEGIN_GGA: begin
          cnt_d  = '0;
          acc_d  = '0;
          seen_d = 1'b0;
          mode_d = mode_q | ((func_e'(func_i) == FUNC_BEGIN_RMC) ? 2'b01 : 2'b10);
        end
        FUNC_FEED: begin
          mode_d = mode_feed;
          if (mode_feed != 2'b00) begin
            if (data_byte_i != CH_COMMA) begin
              if (is_digit) begin
                acc_d  = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0}
                       + {24'd0, digit_off};
                seen_d = 1'b1;
                if (dcnt_q != 4'hF) dcnt_d = dcnt_q + 4'd1;
              end else if (data_byte_i != CH_POINT) begin
                letter_d = data_byte_i;
              end else begin
                dcnt_d = '0;
              end
            end else begin
              cnt_d = cnt_inc;
              if (seen_q) begin
                res.value = acc_q;
                if (mode_feed[0]) begin
                  if (pos_hit(cnt_inc, rmc_q[3:0])) begin
                    res.captured = 1'b1;
                    res.code     = FC_SPEED;
                    flags_d[FLAG_SPEED] = 1'b1;
                  end else if (pos_hit(cnt_inc, rmc_q[11:8])) begin
                    res.captured = 1'b1;
                    res.code     = FC_DATE;
                    flags_d[FLAG_DATE] = 1'b1;
                  end else if (pos_hit(cnt_inc, rmc_q[7:4])) begin
                    res.captured = 1'b1;
                    res.code     = FC_TRACK;
                    flags_d[FLAG_BEARING] = 1'b1;
                  end else if (pos_hit(cnt_inc, rmc_q[15:12])) begin
                    res.captured = 1'b1;
                    res.code     = FC_LONG;
                    res.frac     = dcnt_q;
                  end else if (pos_hit(cnt_inc, rmc_q[19:16])) begin
                    res.captured = 1'b1;
                    res.code     = FC_LAT;
                    res.frac     = dcnt_q;
                  end
                end else begin
                  if (pos_hit(cnt_inc, gga_q[3:0])) begin
                    res.captured = 1'b1;
                    res.code     = FC_TIME;
                    res.is_time  = 1'b1;
                  end else if (pos_hit(cnt_inc, gga_q[7:4])) begin
                    res.captured = 1'b1;
                    res.code     = FC_SATS;
                  end else if (pos_hit(cnt_inc, gga_q[11:8])) begin
                    res.captured = 1'b1;
                    res.code     = FC_HDOP;
                  end else if (pos_hit(cnt_inc, gga_q[15:12])) begin
                    res.captured = 1'b1;
                    res.code     = FC_ALT;
                    flags_d[FLAG_ALTI] = 1'b1;
                  end
                end
                if (!res.captured) res.value = '0;
              end else if (mode_feed[0]) begin
                if (pos_hit(cnt_inc, rmc_q[23:20])) begin
                  res.captured = 1'b1;
                  res.code     = FC_LONGDIR;
                  res.value    = {24'd0, letter_q};
                  flags_d[FLAG_LONG] = 1'b1;
                end else if (pos_hit(cnt_inc, rmc_q[27:24])) begin
                  res.captured = 1'b1;
                  res.code     = FC_LATDIR;
                  res.value    = {24'd0, letter_q};
                  flags_d[FLAG_LAT] = 1'b1;
                end
              end
              acc_d  = '0;
              dcnt_d = '0;
              seen_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.flags = flags_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmc_q    <= RMC_POS_RESET;
      gga_q    <= GGA_POS_RESET;
      mode_q   <= '0;
      cnt_q    <= '0;
      acc_q    <= '0;
      dcnt_q   <= '0;
      seen_q   <= 1'b0;
      letter_q <= '0;
      flags_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RMC_POS: rmc_q <= cfg_data_i[27:0];
          CFG_GGA_POS: gga_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      dcnt_q   <= dcnt_d;
      seen_q   <= seen_d;
      letter_q <= letter_d;
      flags_q  <= flags_d;
    end
  end

endmodule

// File: hw/rtl/nmeax_div_pipe.sv
// Three-stage result pipeline: capture register, reciprocal partial products,
// time quotient and output register. Depends on nmeax_pkg.
module nmeax_div_pipe import nmeax_pkg::*; #(
  parameter int unsigned TIME_DIVISOR = TIME_DIVISOR_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  localparam int unsigned SHIFT_L = $clog2(TIME_DIVISOR);
  localparam int unsigned SHIFT   = 32 + SHIFT_L;
  localparam logic [63:0] MUL_FULL =
    ((64'd1 << SHIFT) + 64'(TIME_DIVISOR) - 64'd1) / 64'(TIME_DIVISOR);
  localparam logic [32:0] MUL    = MUL_FULL[32:0];
  localparam int unsigned PROD_W = 65 + SHIFT_L;

  logic        v1_q, v2_q, v3_q;
  logic        rdy1, rdy2, rdy3;
  res_t        r1_q, r2_q, r3_q;
  logic [48:0] plo_q, phi_q;
  logic [PROD_W-1:0] prod;
  res_t        r3_d;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign prod = {{(PROD_W-65){1'b0}}, phi_q, 16'd0}
              + {{(PROD_W-49){1'b0}}, plo_q};

  always_comb begin
    r3_d = r2_q;
    if (r2_q.is_time) r3_d.value = prod[SHIFT +: 32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) r1_q <= in_res_i;
    if (rdy2) begin
      r2_q  <= r1_q;
      plo_q <= {33'd0, r1_q.value[15:0]} * {16'd0, MUL};
      phi_q <= {33'd0, r1_q.value[31:16]} * {16'd0, MUL};
    end
    if (rdy3) r3_q <= r3_d;
  end

  assign out_valid_o = v3_q;
  assign out_res_o   = r3_q;

endmodule

// File: hw/rtl/nmea_rmc_gga_field_extractor.sv
// Channel   | Group   | Payload (low bit up)
// ----------+---------+------------------------------------------------------
// input     | s_axis  | tuser: func[1:0]; tdata: data_byte[7:0], clear_mask[13:8]
// result    | m_axis  | tuser: captured[0], field_code[4:1];
//           |         | tdata: field_value[31:0], frac_digits[35:32], new_flags[41:36]
// config    | cfg     | cfg_we_i, cfg_idx_i (0 rmc, 1 gga), cfg_data_i
//
// One item per cycle unless m_axis stalls; results pass capture, product, output registers.
// Sentence state updates in the cycle the item is taken; the time quotient is a
// reciprocal multiply split into two partial products over the next two stages.
// Reset clears sentence state and flags and loads the default comma positions.
// A stall on m_axis holds the pipeline; s_axis_tready_o drops only when all stages are full.
module nmea_rmc_gga_field_extractor import nmeax_pkg::*; #(
  parameter int unsigned TIME_DIVISOR = TIME_DIVISOR_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // data_byte, clear_mask
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,   // func
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // field_value, frac_digits, new_flags
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o    // captured, field_code
);

  logic accept;
  res_t parse_res;
  res_t out_res;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  nmeax_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .func_i       (s_axis_tuser_i[1:0]),
    .data_byte_i  (s_axis_tdata_i[7:0]),
    .clear_mask_i (s_axis_tdata_i[13:8]),
    .res_o        (parse_res)
  );

  nmeax_div_pipe #(
    .TIME_DIVISOR (TIME_DIVISOR)
  ) u_div_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_res_i    (parse_res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata_o = {6'd0, out_res.flags, out_res.frac, out_res.value};
  assign m_axis_tuser_o = {out_res.code, out_res.captured};

endmodule

// File: hw/rtl/nmeax_checker.sv
// Port-level checks on the NMEA field extractor, bound to its top level.
// Depends on nmeax_pkg and nmea_rmc_gga_field_extractor_defines.svh.
`include "nmea_rmc_gga_field_extractor_defines.svh"

module nmeax_checker import nmeax_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser_o
);

  `NMEAX_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result item changed while stalled")
  `NMEAX_ASSERT_IMPL(a_idle_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0], m_axis_tuser_o[4:1] == FC_SPEED && m_axis_tdata_o[35:0] == 36'd0, "uncaptured item carries field data")
  `NMEAX_ASSERT_IMPL(a_frac_only_pos, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[4:1] != FC_LONG && m_axis_tuser_o[4:1] != FC_LAT, m_axis_tdata_o[35:32] == 4'd0, "digit count on a field other than long or lat")
  `NMEAX_ASSERT_IMPL(a_dir_flag, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0] && (m_axis_tuser_o[4:1] == FC_LONGDIR || m_axis_tuser_o[4:1] == FC_LATDIR), m_axis_tdata_o[31:8] == 24'd0 && (m_axis_tdata_o[40] || m_axis_tdata_o[41]), "direction item without letter code or flag")

endmodule

bind nmea_rmc_gga_field_extractor nmeax_checker u_nmeax_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// File: dv/nmea_rmc_gga_field_extractor_tb.sv
// Self-checking testbench for the NMEA RMC/GGA field extractor.
// Uses nmeax_pkg and the nmea_rmc_gga_field_extractor RTL; stands alone otherwise.
// Feeds directed and random sentences, predicts every result and checks it in order.
`timescale 1ns / 100ps

module nmea_rmc_gga_field_extractor_tb;
  import nmeax_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 80;

  typedef struct packed {
    logic        cap;
    field_code_e code;
    logic [31:0] value;
    logic [3:0]  frac;
    logic [5:0]  flags;
  } field_report_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // data_byte, clear_mask
  logic [IN_TUSER_W-1:0]  s_tuser = '0;   // func
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // field_value, frac_digits, new_flags
  logic [OUT_TUSER_W-1:0] m_tuser;        // captured, field_code

  // predictor copy of the block
  logic [27:0] rmc_pos_cfg = RMC_POS_RESET;
  logic [15:0] gga_pos_cfg = GGA_POS_RESET;
  logic [1:0]  sent_mode = '0;
  logic [4:0]  comma_cnt = '0;
  logic [31:0] num_acc = '0;
  logic [3:0]  digit_cnt = '0;
  logic        digit_seen_q = 1'b0;
  logic [7:0]  last_letter_q = '0;
  logic [5:0]  value_flags_q = '0;

  field_report_t pending_reports[$];
  field_report_t got_rep, want_rep;

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned item_cnt = 0;
  int unsigned sentence_cnt = 0;
  int unsigned capture_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned config_cnt = 0;
  int unsigned burst_left = 0;
  bit          pace_off = 1'b0;
  int unsigned rx_left = 0;
  int unsigned rx_period = 1;
  int unsigned rx_low = 0;
  int unsigned rx_tick = 0;

  nmea_rmc_gga_field_extractor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_reports.size());
      $display("nmea_rmc_gga_field_extractor verification failed");
      $finish;
    end
  end

  // receiver stall pattern: m_tready low while rx_tick is below rx_low; rx_tick wraps at rx_period
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_period = $urandom_range(2, 12);
      rx_low = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, rx_period - 1);
      rx_left = $urandom_range(50, 300);
      rx_tick = 0;
    end
    rx_left--;
    rx_tick = (rx_tick + 1) % rx_period;
    m_tready = (rx_tick >= rx_low);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got_rep.cap = m_tuser[0];
      got_rep.code = field_code_e'(m_tuser[4:1]);
      got_rep.value = m_tdata[31:0];
      got_rep.frac = m_tdata[35:32];
      got_rep.flags = m_tdata[41:36];
      result_cnt++;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result cap=%0b code=%0d value=%h", $realtime,
                   got_rep.cap, got_rep.code, got_rep.value);
      end else begin
        want_rep = pending_reports.pop_front();
        if (want_rep.cap) capture_cnt++;
        if (got_rep.cap !== want_rep.cap || got_rep.code !== want_rep.code ||
            got_rep.value !== want_rep.value || got_rep.frac !== want_rep.frac ||
            got_rep.flags !== want_rep.flags) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: mismatch exp cap=%0b code=%0d value=%h frac=%0d flags=%b",
                     $realtime, want_rep.cap, want_rep.code, want_rep.value,
                     want_rep.frac, want_rep.flags);
            $display("  got cap=%0b code=%0d value=%h frac=%0d flags=%b",
                     got_rep.cap, got_rep.code, got_rep.value, got_rep.frac,
                     got_rep.flags);
          end
        end
      end
    end
  end

  function automatic logic [4:0] slot(logic [27:0] regv, int k);
    return {1'b0, regv[4*k +: 4]};
  endfunction

  function automatic void extract_step(func_e f, logic [7:0] ch, logic [5:0] clr);
    field_report_t r;
    logic [4:0] n;
    r = '0;
    item_cnt++;
    value_flags_q &= ~clr;
    if (f == FUNC_BEGIN_RMC || f == FUNC_BEGIN_GGA) begin
      comma_cnt = '0;
      num_acc = '0;
      digit_seen_q = 1'b0;
      sent_mode |= (f == FUNC_BEGIN_RMC) ? 2'b01 : 2'b10;
    end else if (f == FUNC_FEED) begin
      if (ch == CH_STAR) sent_mode = '0;
      if (sent_mode != 0) begin
        if (ch == CH_COMMA) begin
          comma_cnt = comma_cnt + 5'd1;
          n = comma_cnt;
          if (digit_seen_q) begin
            r.value = num_acc;
            r.cap = 1'b1;
            if (sent_mode[0]) begin
              if (n == slot(rmc_pos_cfg, 0)) begin
                r.code = FC_SPEED;
                value_flags_q[FLAG_SPEED] = 1'b1;
              end else if (n == slot(rmc_pos_cfg, 2)) begin
                r.code = FC_DATE;
                value_flags_q[FLAG_DATE] = 1'b1;
              end else if (n == slot(rmc_pos_cfg, 1)) begin
                r.code = FC_TRACK;
                value_flags_q[FLAG_BEARING] = 1'b1;
              end else if (n == slot(rmc_pos_cfg, 3)) begin
                r.code = FC_LONG;
                r.frac = digit_cnt;
              end else if (n == slot(rmc_pos_cfg, 4)) begin
                r.code = FC_LAT;
                r.frac = digit_cnt;
              end else begin
                r = '0;
              end
            end else begin
              if (n == slot(28'(gga_pos_cfg), 0)) begin
                r.code = FC_TIME;
                r.value = num_acc / TIME_DIVISOR_DEF;
              end else if (n == slot(28'(gga_pos_cfg), 1)) begin
                r.code = FC_SATS;
              end else if (n == slot(28'(gga_pos_cfg), 2)) begin
                r.code = FC_HDOP;
              end else if (n == slot(28'(gga_pos_cfg), 3)) begin
                r.code = FC_ALT;
                value_flags_q[FLAG_ALTI] = 1'b1;
              end else begin
                r = '0;
              end
            end
          end else if (sent_mode[0]) begin
            if (n == slot(rmc_pos_cfg, 5)) begin
              r.cap = 1'b1;
              r.code = FC_LONGDIR;
              r.value = {24'd0, last_letter_q};
              value_flags_q[FLAG_LONG] = 1'b1;
            end else if (n == slot(rmc_pos_cfg, 6)) begin
              r.cap = 1'b1;
              r.code = FC_LATDIR;
              r.value = {24'd0, last_letter_q};
              value_flags_q[FLAG_LAT] = 1'b1;
            end
          end
          num_acc = '0;
          digit_cnt = '0;
          digit_seen_q = 1'b0;
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
          num_acc = num_acc * 32'd10 + 32'(ch - CH_ZERO);
          digit_seen_q = 1'b1;
          if (digit_cnt != 4'd15) digit_cnt++;
        end else if (ch == CH_POINT) begin
          digit_cnt = '0;
        end else begin
          last_letter_q = ch;
        end
      end
    end
    r.flags = value_flags_q;
    pending_reports.push_back(r);
  endfunction

  function automatic logic [5:0] rand_clear();
    return ($urandom_range(0, 6) == 0) ? 6'($urandom) : 6'd0;
  endfunction

  task automatic send_item(func_e f, logic [7:0] ch, logic [5:0] clr);
    if (!pace_off) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk_i);
          s_tvalid = 1'b0;
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tdata = {2'b00, clr, ch};
    s_tuser = f;
    do @(posedge clk_i); while (!s_tready);
    extract_step(f, ch, clr);
  endtask

  // occasional noise item ahead of the intended byte
  task automatic send_char(logic [7:0] ch);
    if ($urandom_range(0, 29) == 0)
      send_item(func_e'($urandom_range(0, 3)), 8'($urandom), 6'($urandom));
    send_item(FUNC_FEED, ch, rand_clear());
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(FUNC_FEED, s[i], 6'd0);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_positions(logic [CFG_IDX_W-1:0] idx, logic [27:0] val);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == CFG_RMC_POS) rmc_pos_cfg = val;
    else gga_pos_cfg = val[15:0];
    config_cnt++;
  endtask

  task automatic test_gga_time();
    send_item(FUNC_NOP, 8'h00, 6'h3F);
    send_item(FUNC_FEED, 8'hFF, 6'h00);
    send_item(FUNC_BEGIN_GGA, 8'hFF, 6'h00);
    send_text(",12345,");
    send_item(FUNC_FEED, CH_STAR, 6'h3F);
  endtask

  // all RMC positions equal: speed wins; an RMC begin on top of GGA leaves RMC in charge
  task automatic test_collision_precedence();
    write_positions(CFG_RMC_POS, 28'h1111111);
    write_positions(CFG_GGA_POS, 28'h000FFFF);
    send_item(FUNC_BEGIN_GGA, 8'h00, 6'h00);
    send_item(FUNC_BEGIN_RMC, 8'h00, 6'h00);
    send_text("7,");
    send_item(FUNC_FEED, CH_STAR, 6'h00);
  endtask

  task automatic test_direction_fraction();
    write_positions(CFG_RMC_POS, 28'h7654321);
    send_item(FUNC_BEGIN_RMC, 8'h00, 6'h00);
    send_text(",,,12.345,9.,E,,");
    send_item(FUNC_NOP, CH_STAR, 6'h3F);
    send_item(FUNC_FEED, CH_STAR, 6'h00);
  endtask

  task automatic gen_sentence();
    int nf;
    int kind;
    int nd;
    logic [7:0] ch;
    sentence_cnt++;
    send_item($urandom_range(0, 1) ? FUNC_BEGIN_RMC : FUNC_BEGIN_GGA, 8'($urandom),
              rand_clear());
    if ($urandom_range(0, 7) == 0)
      send_item($urandom_range(0, 1) ? FUNC_BEGIN_RMC : FUNC_BEGIN_GGA, 8'($urandom),
                rand_clear());
    nf = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(3, 15);
    repeat (nf) begin
      kind = $urandom_range(0, 9);
      if (kind >= 3 && kind < 5) begin
        repeat ($urandom_range(1, 2)) begin
          ch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(65, 90));
          if ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_COMMA || ch == CH_POINT ||
              ch == CH_STAR)
            ch = 8'h58;
          send_char(ch);
        end
      end else if (kind >= 5) begin
        nd = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 6);
        repeat (nd) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          send_char(CH_POINT);
          nd = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
          repeat (nd) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
      send_char(CH_COMMA);
    end
    if ($urandom_range(0, 4) != 0) begin
      send_char(CH_STAR);
      repeat (2) send_char(8'($urandom));
    end
  endtask

  task automatic test_random_sentences();
    logic [27:0] rmc_set;
    logic [15:0] gga_set;
    int unsigned goal;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin rmc_set = RMC_POS_RESET; gga_set = GGA_POS_RESET; end
        1: begin rmc_set = 28'hFFFFFFF; gga_set = 16'hFFFF; end
        2: begin rmc_set = '0; gga_set = '0; end
        default: begin
          for (int k = 0; k < 7; k++) rmc_set[4*k +: 4] = 4'($urandom_range(1, 12));
          for (int k = 0; k < 4; k++) gga_set[4*k +: 4] = 4'($urandom_range(1, 12));
        end
      endcase
      write_positions(CFG_RMC_POS, rmc_set);
      write_positions(CFG_GGA_POS, 28'(gga_set));
      pace_off = (p == 1);
      goal = item_cnt + PHASE_ITEMS;
      while (item_cnt < goal - PHASE_ITEMS / 2) gen_sentence();
      wait_drained();
      while (item_cnt < goal) gen_sentence();
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_gga_time();
    test_collision_precedence();
    test_direction_fraction();
    test_random_sentences();
    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("covered %0d items in %0d random sentences over %0d register writes",
             item_cnt, sentence_cnt, config_cnt);
    $display("checked %0d results, %0d with a field captured, %0d mismatches",
             result_cnt, capture_cnt, errors);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("nmea_rmc_gga_field_extractor verification clean");
    end else begin
      $display("nmea_rmc_gga_field_extractor verification failed");
    end
    $finish;
  end

endmodule
